[rtl/jse_pkg.sv]
// shared types, character codes and byte classification helpers for the escaper
package jse_pkg;

   localparam logic [1:0] KIND_LIT   = 2'd0;
   localparam logic [1:0] KIND_SHORT = 2'd1;
   localparam logic [1:0] KIND_HEX   = 2'd2;

   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_ZERO   = 8'h30;

   localparam logic [2:0] STEP_LAST_SHORT = 3'd1;
   localparam logic [2:0] STEP_LAST_HEX   = 3'd5;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
   } op_type;

   function automatic logic [2:0] seq_len(input logic [7:0] lead);
      logic [2:0] len;
      if (lead inside {[8'hc2:8'hdf]}) begin
         len = 3'd2;
      end else if (lead inside {[8'he0:8'hef]}) begin
         len = 3'd3;
      end else if (lead inside {[8'hf0:8'hf4]}) begin
         len = 3'd4;
      end else begin
         len = 3'd0;
      end
      return len;
   endfunction

   function automatic logic byte_ok(input logic [7:0] lead, input logic [1:0] pos,
                                    input logic [7:0] b);
      logic ok;
      ok = ((b & 8'hc0) == 8'h80);
      if (pos == 2'd1) begin
         if (lead == 8'he0) begin
            ok = b inside {[8'ha0:8'hbf]};
         end else if (lead == 8'hed) begin
            ok = b inside {[8'h80:8'h9f]};
         end else if (lead == 8'hf0) begin
            ok = b inside {[8'h90:8'hbf]};
         end else if (lead == 8'hf4) begin
            ok = b inside {[8'h80:8'h8f]};
         end
      end
      return ok;
   endfunction

   function automatic logic [1:0] fresh_kind(input logic [7:0] b);
      logic [1:0] k;
      if (b inside {8'h5c, 8'h22, 8'h08, 8'h0c, 8'h0a, 8'h0d, 8'h09}) begin
         k = KIND_SHORT;
      end else if (b < 8'h20) begin
         k = KIND_HEX;
      end else if (b < 8'h80) begin
         k = KIND_LIT;
      end else begin
         k = KIND_HEX;
      end
      return k;
   endfunction

   function automatic logic [7:0] short_char(input logic [7:0] b);
      logic [7:0] c;
      case (b)
         8'h08:   c = 8'h62;
         8'h0c:   c = 8'h66;
         8'h0a:   c = 8'h6e;
         8'h0d:   c = 8'h72;
         8'h09:   c = 8'h74;
         8'h22:   c = CH_QUOTE;
         default: c = CH_BSLASH;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = 8'h30 + {4'h0, nib};
      end else begin
         c = 8'h57 + {4'h0, nib};
      end
      return c;
   endfunction

endpackage

[rtl/json_string_escaper_utf8.sv]
// top level of the json string escaper with utf-8 sequence check
//
//   channel   ports                                   direction
//   request   push full in_byte end_of_text           in
//   response  empty pop out_byte last_out             out
//
// a request that yields at most one op is taken every cycle; larger ones hold full
// until the last op is pushed (up to four ops: three held bytes and the new byte)
// a request still issuing ops also holds full while the op queue is full
// the response side gives one byte per cycle while pop is high and ops wait;
// escapes expand to two or six bytes, paced by the expander in the back end
// a four-entry op queue separates the two ends, so each stalls on its own
// reset is synchronous and clears the held count, queue and output valid flag
module json_string_escaper_utf8
   import jse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_text,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_out
);

   op_type q_wr_op;
   op_type q_rd_op;
   logic   q_push;
   logic   q_full;
   logic   q_pop;
   logic   q_empty;

   jse_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .in_byte     (req_in_byte),
      .end_of_text (req_end_of_text),
      .op_push     (q_push),
      .op          (q_wr_op),
      .op_full     (q_full)
   );

   jse_queue u_queue (
      .clock (clock),
      .reset (reset),
      .wr_en (q_push),
      .wr_op (q_wr_op),
      .full  (q_full),
      .rd_en (q_pop),
      .rd_op (q_rd_op),
      .empty (q_empty)
   );

   jse_back u_back (
      .clock    (clock),
      .reset    (reset),
      .op       (q_rd_op),
      .op_empty (q_empty),
      .op_pop   (q_pop),
      .empty    (empty),
      .pop      (pop),
      .out_byte (rsp_out_byte),
      .last_out (rsp_last_out)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("op pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("op popped from an empty queue");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty)
      else $error("response pending right after reset");

endmodule

[rtl/jse_front.sv]
// front end: takes raw bytes, tracks the held utf-8 sequence and issues escape ops
module jse_front
   import jse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] in_byte,
   input  logic       end_of_text,
   output logic       op_push,
   output op_type     op,
   input  logic       op_full
);

   logic [7:0] held_ff [3];
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;

   logic [7:0] pheld_ff [3];
   logic [7:0] pb_ff;
   logic [1:0] pbkind_ff;
   logic [1:0] phkind_ff;
   logic [1:0] pm_ff;
   logic [1:0] plastidx_ff;
   logic       pend_ff;
   logic       busy_ff;
   logic       busy_in;
   logic [1:0] idx_ff;
   logic [1:0] idx_in;

   logic       accept;
   logic       done;
   logic [2:0] len;
   logic       is_lead;
   logic       tail_ok;
   logic       complete;
   logic [1:0] m;
   logic [1:0] hk;
   logic [1:0] bk;
   logic       bpres;
   logic       hold_wr;
   logic [1:0] wr_idx;
   logic [2:0] total;
   logic [7:0] sel_byte;

   assign accept = push && !full;

   always_comb begin
      len      = seq_len(held_ff[0]);
      is_lead  = (seq_len(in_byte) != 3'd0);
      tail_ok  = byte_ok(held_ff[0], cnt_ff, in_byte);
      complete = (({1'b0, cnt_ff} + 3'd1) >= len);
      m        = cnt_ff;
      hk       = KIND_HEX;
      bk       = fresh_kind(in_byte);
      bpres    = 1'b1;
      hold_wr  = 1'b0;
      wr_idx   = 2'd0;
      cnt_in   = 2'd0;
      if (cnt_ff == 2'd0 || !tail_ok) begin
         if (is_lead && !end_of_text) begin
            bpres   = 1'b0;
            hold_wr = 1'b1;
            wr_idx  = 2'd0;
            cnt_in  = 2'd1;
         end
      end else if (complete) begin
         hk = KIND_LIT;
         bk = KIND_LIT;
      end else if (!end_of_text) begin
         bpres   = 1'b0;
         m       = 2'd0;
         hold_wr = 1'b1;
         wr_idx  = cnt_ff;
         cnt_in  = cnt_ff + 2'd1;
      end
      total = {1'b0, m} + {2'b00, bpres};
   end

   // op sequencer over the latched held bytes and the new byte
   always_comb begin
      case (idx_ff)
         2'd0:    sel_byte = pheld_ff[0];
         2'd1:    sel_byte = pheld_ff[1];
         2'd2:    sel_byte = pheld_ff[2];
         default: sel_byte = pb_ff;
      endcase
      if (idx_ff == pm_ff) begin
         op.data = pb_ff;
         op.kind = pbkind_ff;
      end else begin
         op.data = sel_byte;
         op.kind = phkind_ff;
      end
      op.last = pend_ff && (idx_ff == plastidx_ff);
   end

   assign op_push = busy_ff && !op_full;
   assign done    = op_push && (idx_ff == plastidx_ff);
   assign full    = busy_ff && !done;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (op_push) begin
         idx_in = idx_ff + 2'd1;
      end
      if (done) begin
         busy_in = 1'b0;
      end
      if (accept) begin
         busy_in = (total != 3'd0);
         idx_in  = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 2'd0;
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         if (accept) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pheld_ff    <= held_ff;
         pb_ff       <= in_byte;
         pbkind_ff   <= bk;
         phkind_ff   <= hk;
         pm_ff       <= m;
         plastidx_ff <= total[1:0] - 2'd1;
         pend_ff     <= end_of_text;
         if (hold_wr) begin
            held_ff[wr_idx] <= in_byte;
         end
      end
   end

endmodule

[rtl/jse_queue.sv]
// short op queue between the front end and the byte expander
module jse_queue
   import jse_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   wr_en,
   input  op_type wr_op,
   output logic   full,
   input  logic   rd_en,
   output op_type rd_op,
   output logic   empty
);

   op_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wp_ff;
   logic [QPTR_W-1:0] rp_ff;
   logic [QPTR_W:0]   count_ff;
   logic              do_wr;
   logic              do_rd;

   assign full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && !empty;
   assign rd_op = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_wr) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (do_rd) begin
            rp_ff <= rp_ff + 1'b1;
         end
         count_ff <= count_ff + (QPTR_W+1)'(do_wr) - (QPTR_W+1)'(do_rd);
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wp_ff] <= wr_op;
      end
   end

endmodule

[rtl/jse_back.sv]
// back end: expands each op into escaped bytes behind an output register
module jse_back
   import jse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  op_type     op,
   input  logic       op_empty,
   output logic       op_pop,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] out_byte,
   output logic       last_out
);

   logic [2:0] step_ff;
   logic [2:0] step_in;
   logic       ov_ff;
   logic       ov_in;
   logic [7:0] ob_ff;
   logic       ol_ff;
   logic       take;
   logic       load;
   logic       final_step;
   logic [7:0] nbyte;

   assign take = pop && ov_ff;
   assign load = !op_empty && (!ov_ff || take);

   always_comb begin
      final_step = 1'b1;
      nbyte      = op.data;
      case (op.kind)
         KIND_SHORT: begin
            final_step = (step_ff == STEP_LAST_SHORT);
            nbyte      = final_step ? short_char(op.data) : CH_BSLASH;
         end
         KIND_HEX: begin
            final_step = (step_ff == STEP_LAST_HEX);
            case (step_ff)
               3'd0:    nbyte = CH_BSLASH;
               3'd1:    nbyte = CH_U;
               3'd2:    nbyte = CH_ZERO;
               3'd3:    nbyte = CH_ZERO;
               3'd4:    nbyte = hex_char(op.data[7:4]);
               default: nbyte = hex_char(op.data[3:0]);
            endcase
         end
         default: begin
            final_step = 1'b1;
            nbyte      = op.data;
         end
      endcase
   end

   assign op_pop = load && final_step;

   always_comb begin
      step_in = step_ff;
      ov_in   = ov_ff;
      if (take) begin
         ov_in = 1'b0;
      end
      if (load) begin
         ov_in   = 1'b1;
         step_in = final_step ? 3'd0 : step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 3'd0;
         ov_ff   <= 1'b0;
      end else begin
         step_ff <= step_in;
         ov_ff   <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ob_ff <= nbyte;
         ol_ff <= op.last && final_step;
      end
   end

   assign empty    = !ov_ff;
   assign out_byte = ob_ff;
   assign last_out = ol_ff;

endmodule

[tb/sv/json_string_escaper_utf8_test.sv]
// self-checking testbench for the json string escaper with utf-8 sequence check
`timescale 1ns / 1ps

module json_string_escaper_utf8_test
   import jse_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT  = 2000000;
   localparam int unsigned TEXT_ITEMS   = 320;
   localparam int unsigned SETTLE_WAIT  = 20;
   localparam int unsigned SHOW_LIMIT   = 10;

   localparam logic [7:0] C_BS        = 8'h08;
   localparam logic [7:0] C_TAB       = 8'h09;
   localparam logic [7:0] C_LF        = 8'h0a;
   localparam logic [7:0] C_FF        = 8'h0c;
   localparam logic [7:0] C_CR        = 8'h0d;
   localparam logic [7:0] CH_LOWER_A  = 8'h61;
   localparam logic [7:0] CH_LOWER_B  = 8'h62;
   localparam logic [7:0] CH_LOWER_F  = 8'h66;
   localparam logic [7:0] CH_LOWER_N  = 8'h6e;
   localparam logic [7:0] CH_LOWER_R  = 8'h72;
   localparam logic [7:0] CH_LOWER_T  = 8'h74;

   localparam int unsigned UTF_WHOLE = 0;
   localparam int unsigned UTF_CUT   = 1;
   localparam int unsigned UTF_BAD   = 2;

   typedef struct {
      logic [7:0]  data;
      logic        eot;
      int unsigned gap;
      bit          wait_drain;
   } text_req_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } escaped_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic       full;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_end_of_text = 1'b0;
   logic       empty;
   logic       pop = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_out;

   text_req_type     pending[$];
   escaped_byte_type awaited_bytes[$];
   logic [7:0]       step_bytes[$];

   logic [7:0]  utf_held [3] = '{8'h00, 8'h00, 8'h00};
   int unsigned utf_held_n = 0;

   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;
   int unsigned idle_left = 0;
   bit          drain_done = 1'b0;
   int unsigned stall_left = 0;
   int unsigned steady_left = 0;
   bit          string_steady = 1'b0;
   bit          drain_next = 1'b0;

   json_string_escaper_utf8 dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_in_byte     (req_in_byte),
      .req_end_of_text (req_end_of_text),
      .empty           (empty),
      .pop             (pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_out    (rsp_last_out)
   );

   always #1 clock = ~clock;

   // escape prediction
   function automatic int unsigned lead_span(input logic [7:0] lead);
      int unsigned len;
      if (lead >= 8'hc2 && lead <= 8'hdf) begin
         len = 2;
      end else if (lead >= 8'he0 && lead <= 8'hef) begin
         len = 3;
      end else if (lead >= 8'hf0 && lead <= 8'hf4) begin
         len = 4;
      end else begin
         len = 0;
      end
      return len;
   endfunction

   function automatic bit cont_fits(input logic [7:0] lead, input int unsigned pos,
                                    input logic [7:0] b);
      bit fits;
      fits = (b[7:6] == 2'b10);
      if (pos == 1) begin
         if (lead == 8'he0) begin
            fits = (b >= 8'ha0 && b <= 8'hbf);
         end else if (lead == 8'hed) begin
            fits = (b >= 8'h80 && b <= 8'h9f);
         end else if (lead == 8'hf0) begin
            fits = (b >= 8'h90 && b <= 8'hbf);
         end else if (lead == 8'hf4) begin
            fits = (b >= 8'h80 && b <= 8'h8f);
         end
      end
      return fits;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = CH_ZERO + {4'h0, nib};
      end else begin
         c = CH_LOWER_A + {4'h0, nib} - 8'd10;
      end
      return c;
   endfunction

   function automatic void emit_byte(input logic [7:0] b);
      step_bytes.insert(step_bytes.size(), b);
   endfunction

   function automatic void put_hex(input logic [7:0] v);
      emit_byte(CH_BSLASH);
      emit_byte(CH_U);
      emit_byte(CH_ZERO);
      emit_byte(CH_ZERO);
      emit_byte(hex_digit(v[7:4]));
      emit_byte(hex_digit(v[3:0]));
   endfunction

   function automatic void put_short(input logic [7:0] c);
      emit_byte(CH_BSLASH);
      emit_byte(c);
   endfunction

   function automatic void escape_fresh(input logic [7:0] b);
      case (b)
         CH_BSLASH: put_short(CH_BSLASH);
         CH_QUOTE:  put_short(CH_QUOTE);
         C_BS:      put_short(CH_LOWER_B);
         C_FF:      put_short(CH_LOWER_F);
         C_LF:      put_short(CH_LOWER_N);
         C_CR:      put_short(CH_LOWER_R);
         C_TAB:     put_short(CH_LOWER_T);
         default: begin
            if (b < 8'h20) begin
               put_hex(b);
            end else if (b < 8'h80) begin
               emit_byte(b);
            end else if (lead_span(b) != 0) begin
               utf_held[0] = b;
               utf_held_n = 1;
            end else begin
               put_hex(b);
            end
         end
      endcase
   endfunction

   // escape the lead, replay the held continuations
   function automatic void drop_held();
      logic [7:0]  saved [3];
      int unsigned n;
      int unsigned k;
      n = utf_held_n;
      for (k = 0; k < 3; k++) saved[k] = utf_held[k];
      utf_held_n = 0;
      put_hex(saved[0]);
      for (k = 1; k < n; k++) escape_fresh(saved[k]);
   endfunction

   function automatic void escape_byte(input logic [7:0] b);
      logic [7:0]  lead;
      int unsigned k;
      lead = utf_held[0];
      if (utf_held_n == 0) begin
         escape_fresh(b);
      end else if (cont_fits(lead, utf_held_n, b)) begin
         if (utf_held_n + 1 >= lead_span(lead)) begin
            for (k = 0; k < utf_held_n; k++) emit_byte(utf_held[k]);
            emit_byte(b);
            utf_held_n = 0;
         end else begin
            utf_held[utf_held_n] = b;
            utf_held_n = utf_held_n + 1;
         end
      end else begin
         drop_held();
         escape_fresh(b);
      end
   endfunction

   function automatic void predict_request(input logic [7:0] b, input logic eot);
      escaped_byte_type item;
      int unsigned      k;
      step_bytes.delete();
      escape_byte(b);
      if (eot) begin
         while (utf_held_n != 0) drop_held();
      end
      for (k = 0; k < step_bytes.size(); k++) begin
         item.data = step_bytes[k];
         item.last = eot && (k == step_bytes.size() - 1);
         awaited_bytes.insert(awaited_bytes.size(), item);
      end
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      int unsigned g;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         g = 0;
      end else if (r < 90) begin
         g = $urandom_range(1, 3);
      end else begin
         g = $urandom_range(8, 40);
      end
      return g;
   endfunction

   // request building
   task automatic add_byte(input logic [7:0] b);
      text_req_type item;
      item.data = b;
      item.eot = 1'b0;
      item.gap = string_steady ? 0 : pick_gap();
      item.wait_drain = drain_next;
      pending.insert(pending.size(), item);
      drain_next = 1'b0;
   endtask

   task automatic end_string();
      pending[pending.size() - 1].eot = 1'b1;
   endtask

   task automatic add_utf8(input int unsigned mode);
      logic [7:0]  seq [4];
      int unsigned len;
      int unsigned keep;
      int unsigned k;
      len = $urandom_range(2, 4);
      case (len)
         2:       seq[0] = 8'($urandom_range(8'hc2, 8'hdf));
         3:       seq[0] = 8'($urandom_range(8'he0, 8'hef));
         default: seq[0] = 8'($urandom_range(8'hf0, 8'hf4));
      endcase
      for (k = 1; k < 4; k++) seq[k] = 8'($urandom_range(8'h80, 8'hbf));
      if (seq[0] == 8'he0) begin
         seq[1] = 8'($urandom_range(8'ha0, 8'hbf));
      end else if (seq[0] == 8'hed) begin
         seq[1] = 8'($urandom_range(8'h80, 8'h9f));
      end else if (seq[0] == 8'hf0) begin
         seq[1] = 8'($urandom_range(8'h90, 8'hbf));
      end else if (seq[0] == 8'hf4) begin
         seq[1] = 8'($urandom_range(8'h80, 8'h8f));
      end
      keep = len;
      if (mode == UTF_CUT) begin
         keep = $urandom_range(1, len - 1);
      end else if (mode == UTF_BAD) begin
         seq[$urandom_range(1, len - 1)] = 8'($urandom);
      end
      for (k = 0; k < keep; k++) add_byte(seq[k]);
   endtask

   // request driver
   always @(posedge clock) begin
      text_req_type next_req;
      if (!reset) begin
         if (push && !full) begin
            predict_request(req_in_byte, req_end_of_text);
         end
         if (!push || !full) begin
            if (idle_left != 0) begin
               push <= 1'b0;
               idle_left <= idle_left - 1;
            end else if (pending.size() != 0 && pending[0].wait_drain && !drain_done) begin
               push <= 1'b0;
               if (awaited_bytes.size() == 0) begin
                  drain_done <= 1'b1;
                  idle_left <= SETTLE_WAIT;
               end
            end else if (pending.size() != 0) begin
               next_req = pending.pop_front();
               push <= 1'b1;
               req_in_byte <= next_req.data;
               req_end_of_text <= next_req.eot;
               idle_left <= next_req.gap;
               drain_done <= 1'b0;
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      escaped_byte_type want;
      int unsigned      r;
      if (!reset) begin
         if (pop && !empty) begin
            if (awaited_bytes.size() == 0) begin
               fail_count = fail_count + 1;
               if (fail_count <= SHOW_LIMIT) begin
                  $display("unexpected byte %h last %b", rsp_out_byte, rsp_last_out);
               end
            end else begin
               want = awaited_bytes.pop_front();
               if (rsp_out_byte !== want.data || rsp_last_out !== want.last) begin
                  fail_count = fail_count + 1;
                  if (fail_count <= SHOW_LIMIT) begin
                     $display("mismatch: expected byte %h last %b, got byte %h last %b",
                              want.data, want.last, rsp_out_byte, rsp_last_out);
                  end
               end
            end
         end
         if (steady_left != 0) begin
            pop <= 1'b1;
            steady_left <= steady_left - 1;
         end else if (stall_left != 0) begin
            pop <= 1'b0;
            stall_left <= stall_left - 1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
               steady_left <= $urandom_range(30, 150);
               pop <= 1'b1;
            end else if (r < 35) begin
               stall_left <= pick_gap();
               pop <= 1'b0;
            end else begin
               pop <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      logic [8:0]  directed_text [29] = '{
         9'h05c, 9'h022, 9'h008, 9'h00c, 9'h00a, 9'h00d, 9'h009, 9'h000, 9'h01f,
         9'h020, 9'h17f,
         9'h080, 9'h0c1, 9'h0f5, 9'h1ff,
         9'h0c2, 9'h0a9,
         9'h0ed, 9'h0a0,
         9'h0f4, 9'h090,
         9'h0e0, 9'h09f,
         9'h0f0, 9'h09f, 9'h098, 9'h180,
         9'h0e2, 9'h182
      };
      logic [7:0]  specials [7] = '{CH_BSLASH, CH_QUOTE, C_BS, C_FF, C_LF, C_CR, C_TAB};
      int unsigned string_count;
      int unsigned segs;
      int unsigned s;
      int unsigned k;
      int unsigned r;

      // directed strings: escapes, boundaries, sequence errors, cut-off end
      foreach (directed_text[i]) begin
         add_byte(directed_text[i][7:0]);
         if (directed_text[i][8]) end_string();
      end

      string_count = 0;
      while (pending.size() < TEXT_ITEMS) begin
         string_steady = ($urandom_range(0, 3) == 0);
         drain_next = (string_count % 8 == 0);
         segs = $urandom_range(1, 6);
         for (s = 0; s < segs; s++) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
               for (k = $urandom_range(1, 4); k != 0; k--) begin
                  add_byte(8'($urandom_range(8'h20, 8'h7f)));
               end
            end else if (r < 40) begin
               k = $urandom_range(0, 9);
               if (k < 7) begin
                  add_byte(specials[k]);
               end else begin
                  add_byte(8'($urandom_range(8'h00, 8'h1f)));
               end
            end else if (r < 70) begin
               add_utf8(UTF_WHOLE);
            end else if (r < 80) begin
               add_utf8(UTF_CUT);
            end else if (r < 90) begin
               add_utf8(UTF_BAD);
            end else begin
               add_byte(8'($urandom));
            end
         end
         end_string();
         string_count++;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending.size() != 0 || push) @(posedge clock);
      while (awaited_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);

      fail_count = fail_count + awaited_bytes.size();
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[files.f]
rtl/jse_pkg.sv
rtl/jse_front.sv
rtl/jse_queue.sv
rtl/jse_back.sv
rtl/json_string_escaper_utf8.sv
tb/sv/json_string_escaper_utf8_test.sv
